>>> sv/double_click_led_chaser_macros.svh
// Assertion macros for the double-click LED chaser checker.
// Included by sv/dclc_checker.sv; no other dependencies.
`ifndef DOUBLE_CLICK_LED_CHASER_MACROS_SVH
`define DOUBLE_CLICK_LED_CHASER_MACROS_SVH

// Same-cycle implication, quiet during reset.
`define DCLC_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dclc check failed");

// Next-cycle implication, quiet during reset.
`define DCLC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dclc check failed");

`endif

>>> sv/dclc_pkg.sv
// Shared types and constants for the double-click LED chaser.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package dclc_pkg;

  localparam int unsigned CNT_W   = 12;
  localparam int unsigned DEB_W   = 10;
  localparam int unsigned DCLK_W  = 10;
  localparam int unsigned BLINK_W = 12;
  localparam int unsigned CFG_W   = 12;
  localparam int unsigned CFG_A_W = 2;
  localparam int unsigned TDATA_W = 8;

  localparam logic [CNT_W-1:0]   CNT_MAX         = 12'hFFF;
  localparam logic [DEB_W-1:0]   DEBOUNCE_RESET  = 10'd50;
  localparam logic [DCLK_W-1:0]  DCLICK_RESET    = 10'd300;
  localparam logic [BLINK_W-1:0] BLINK_RESET     = 12'd500;

  typedef enum logic [CFG_A_W-1:0] {
    CFG_DEBOUNCE = 2'd0,
    CFG_DCLICK   = 2'd1,
    CFG_BLINK    = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_START = 2'd1,
    CMD_STOP  = 2'd2
  } remote_cmd_t;

  // Position codes
  localparam logic [1:0] POS_RED    = 2'd0;
  localparam logic [1:0] POS_YELLOW = 2'd1;
  localparam logic [1:0] POS_GREEN  = 2'd2;

  // Run state handed from the click logic to the chaser
  typedef struct packed {
    logic running;
    logic reverse;
  } run_state_t;

  // Saturating increment of an elapsed counter
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] r;
    r = (v == CNT_MAX) ? CNT_MAX : v + 1'b1;
    return r;
  endfunction

endpackage

>>> sv/dclc_click.sv
// Debounce, click counting and run/direction control for one tick.
// Depends on dclc_pkg.
`timescale 1ns / 1ps

module dclc_click (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              button_down,
  input  logic [1:0]                        remote_cmd,
  input  logic [dclc_pkg::DEB_W-1:0]        debounce_ticks,
  input  logic [dclc_pkg::DCLK_W-1:0]       double_click_ticks,
  output dclc_pkg::run_state_t              run_next
);

  logic                        last_level, last_level_next;
  logic [dclc_pkg::CNT_W-1:0]  since_change, since_change_next;
  logic                        held_down, held_down_next;
  logic [dclc_pkg::CNT_W-1:0]  since_click, since_click_next;
  logic [1:0]                  click_count, click_count_next;
  logic                        running, reverse;
  logic                        stable, press, release_lvl;
  logic [1:0]                  clicks;
  logic                        run_t, rev_t;

  always_comb begin
    last_level_next   = button_down;
    since_change_next = (button_down != last_level) ? '0 : dclc_pkg::sat_inc(since_change);
    stable      = since_change_next > {2'b00, debounce_ticks};
    press       = stable && button_down && !held_down;
    release_lvl = stable && !button_down && held_down;

    since_click_next = dclc_pkg::sat_inc(since_click);
    held_down_next   = held_down;
    clicks           = click_count;
    if (press) begin
      held_down_next = 1'b1;
      if (since_click_next < {2'b00, double_click_ticks}) begin
        clicks = click_count + 2'd1;
      end else begin
        clicks = 2'd1;
      end
      since_click_next = '0;
    end else if (release_lvl) begin
      held_down_next = 1'b0;
    end

    // Double click toggles running; turning on reverses direction
    run_t            = running;
    rev_t            = reverse;
    click_count_next = clicks;
    if (clicks == 2'd2) begin
      run_t            = ~running;
      rev_t            = run_t ? ~reverse : reverse;
      click_count_next = 2'd0;
    end

    // Remote command after the button
    case (remote_cmd)
      dclc_pkg::CMD_START: begin
        run_t = 1'b1;
        rev_t = ~rev_t;
      end
      dclc_pkg::CMD_STOP: begin
        run_t = 1'b0;
      end
      default: begin
      end
    endcase

    run_next.running = run_t;
    run_next.reverse = rev_t;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_level   <= 1'b0;
      since_change <= '0;
      held_down    <= 1'b0;
      since_click  <= dclc_pkg::CNT_MAX;
      click_count  <= 2'd0;
      running      <= 1'b0;
      reverse      <= 1'b0;
    end else if (en) begin
      last_level   <= last_level_next;
      since_change <= since_change_next;
      held_down    <= held_down_next;
      since_click  <= since_click_next;
      click_count  <= click_count_next;
      running      <= run_next.running;
      reverse      <= run_next.reverse;
    end
  end

endmodule

>>> sv/dclc_chaser.sv
// Blink timer, lit-LED position and lamp drive for one tick.
// Depends on dclc_pkg.
`timescale 1ns / 1ps

module dclc_chaser (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          remote_hold,
  input  dclc_pkg::run_state_t          run_next,
  input  logic [dclc_pkg::BLINK_W-1:0]  blink_ticks,
  output logic [2:0]                    led_lamps,
  output logic                          color_event,
  output logic [1:0]                    color_now
);

  logic [dclc_pkg::CNT_W-1:0] since_blink, since_blink_next;
  logic [1:0]                 position, position_next;
  logic [2:0]                 lamp_bits, lamp_bits_next;
  logic                       active, step;

  always_comb begin
    since_blink_next = dclc_pkg::sat_inc(since_blink);
    position_next    = position;
    lamp_bits_next   = lamp_bits;
    active           = run_next.running || remote_hold;
    step             = active && (since_blink_next >= blink_ticks);
    if (step) begin
      since_blink_next = '0;
      if (run_next.reverse) begin
        position_next = (position == dclc_pkg::POS_RED || position > dclc_pkg::POS_GREEN) ?
                        dclc_pkg::POS_GREEN : position - 2'd1;
      end else begin
        position_next = (position >= dclc_pkg::POS_GREEN) ? dclc_pkg::POS_RED
                                                           : position + 2'd1;
      end
      lamp_bits_next = 3'b001 << position_next;
    end else if (!active) begin
      lamp_bits_next = 3'b000;
    end
    led_lamps   = lamp_bits_next;
    color_event = step;
    color_now   = position_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      since_blink <= '0;
      position    <= dclc_pkg::POS_RED;
      lamp_bits   <= 3'b000;
    end else if (en) begin
      since_blink <= since_blink_next;
      position    <= position_next;
      lamp_bits   <= lamp_bits_next;
    end
  end

endmodule

>>> sv/double_click_led_chaser.sv
// Top level of the double-click LED chaser: stream ports, config registers,
// input and result registers. Depends on dclc_pkg, dclc_click, dclc_chaser.
`timescale 1ns / 1ps
//
//  Channel   Direction  Carries
//  --------  ---------  ------------------------------------------------------
//  s_*       in         one millisecond tick: button level, remote cmd, hold
//  m_*       out        one result per tick: lamps, step event, position, run
//  cfg_*     in         register writes: debounce, double-click, blink periods
//
//  One tick transaction is accepted per cycle while m_tready stays high;
//  m_tvalid rises once the tick passes from the input to the result register.
//  All state updates resolve in the single stage between those two registers.
//  rst is synchronous and active high; it loads the default periods and clears
//  all chaser state. A stalled m_tready holds the result and backs up through
//  the input register; s_tready falls only when both registers are full.

module double_click_led_chaser (
  input  logic                          clk,
  input  logic                          rst,
  // tick in: [0] button_down, [2:1] remote_cmd, [3] remote_hold, rest zero
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [dclc_pkg::TDATA_W-1:0]  s_tdata,
  // result out: [2:0] led_lamps, [3] color_event, [5:4] color_now,
  //             [6] run_flag, [7] zero
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [dclc_pkg::TDATA_W-1:0]  m_tdata,
  // configuration writes
  input  logic                          cfg_we,
  input  logic [dclc_pkg::CFG_A_W-1:0]  cfg_addr,
  input  logic [dclc_pkg::CFG_W-1:0]    cfg_data
);

  // Configuration registers
  logic [dclc_pkg::DEB_W-1:0]   debounce_ticks;
  logic [dclc_pkg::DCLK_W-1:0]  double_click_ticks;
  logic [dclc_pkg::BLINK_W-1:0] blink_ticks;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks     <= dclc_pkg::DEBOUNCE_RESET;
      double_click_ticks <= dclc_pkg::DCLICK_RESET;
      blink_ticks        <= dclc_pkg::BLINK_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        dclc_pkg::CFG_DEBOUNCE: debounce_ticks     <= cfg_data[dclc_pkg::DEB_W-1:0];
        dclc_pkg::CFG_DCLICK:   double_click_ticks <= cfg_data[dclc_pkg::DCLK_W-1:0];
        dclc_pkg::CFG_BLINK:    blink_ticks        <= cfg_data[dclc_pkg::BLINK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Input register
  logic       in_valid;
  logic       in_button;
  logic [1:0] in_cmd;
  logic       in_hold;
  logic       advance;

  // Tick is processed when the result register is free or draining
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_button <= s_tdata[0];
      in_cmd    <= s_tdata[2:1];
      in_hold   <= s_tdata[3];
    end
  end

  // Processing stage
  dclc_pkg::run_state_t run_next;
  logic [2:0] led_lamps;
  logic       color_event;
  logic [1:0] color_now;

  dclc_click u_click (
    .clk                (clk),
    .rst                (rst),
    .en                 (advance),
    .button_down        (in_button),
    .remote_cmd         (in_cmd),
    .debounce_ticks     (debounce_ticks),
    .double_click_ticks (double_click_ticks),
    .run_next           (run_next)
  );

  dclc_chaser u_chaser (
    .clk         (clk),
    .rst         (rst),
    .en          (advance),
    .remote_hold (in_hold),
    .run_next    (run_next),
    .blink_ticks (blink_ticks),
    .led_lamps   (led_lamps),
    .color_event (color_event),
    .color_now   (color_now)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {1'b0, run_next.running, color_now, color_event, led_lamps};
    end
  end

endmodule

>>> sv/dclc_checker.sv
// Port-level checker for the double-click LED chaser, bound to the top level.
// Depends on double_click_led_chaser_macros.svh and the top level's ports.
`timescale 1ns / 1ps
`include "double_click_led_chaser_macros.svh"

module dclc_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata
);

  // At most one lamp lit
  `DCLC_ASSERT_SAME(a_one_lamp, clk, rst, m_tvalid, $onehot0(m_tdata[2:0]))

  // Position is always a real colour
  `DCLC_ASSERT_SAME(a_pos_range, clk, rst, m_tvalid, m_tdata[5:4] != 2'd3)

  // A step lights exactly the lamp at the reported position
  `DCLC_ASSERT_SAME(a_step_lamp, clk, rst, m_tvalid && m_tdata[3],
    (m_tdata[5:4] == dclc_pkg::POS_RED    && m_tdata[2:0] == 3'b001) ||
    (m_tdata[5:4] == dclc_pkg::POS_YELLOW && m_tdata[2:0] == 3'b010) ||
    (m_tdata[5:4] == dclc_pkg::POS_GREEN  && m_tdata[2:0] == 3'b100))

  // A stalled result holds
  `DCLC_ASSERT_NEXT(a_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // With the output free, the input side never stalls
  `DCLC_ASSERT_SAME(a_no_stall, clk, rst, !m_tvalid, s_tready)

endmodule

bind double_click_led_chaser dclc_checker u_dclc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

>>> test/tb_double_click_led_chaser.sv
// Self-checking testbench for the double-click LED chaser: random tick streams
// against a cycle-free model of the debounce, click and chaser logic.
// Depends on sv/dclc_pkg.sv and the double_click_led_chaser RTL.
`timescale 1ns / 1ps

import dclc_pkg::*;

// One expected result transaction; check_result compares each field with m_tdata.
typedef struct packed {
  logic [2:0] lamps;
  logic       stepped;
  logic [1:0] spot;
  logic       run;
} lamp_result_t;

class chaser_scoreboard;
  // register copies
  logic [DEB_W-1:0]   debounce_lim;
  logic [DCLK_W-1:0]  dclick_win;
  logic [BLINK_W-1:0] blink_period;
  // chaser state
  logic              seen_level;
  logic [CNT_W-1:0]  stable_age;
  logic              pressed;
  logic [CNT_W-1:0]  click_age;
  logic [1:0]        clicks;
  logic              running;
  logic              backwards;
  logic [1:0]        spot;
  logic [2:0]        lamps;
  logic [CNT_W-1:0]  blink_age;

  lamp_result_t expected_results[$];
  int unsigned  mismatches;

  function new();
    debounce_lim = DEBOUNCE_RESET;
    dclick_win   = DCLICK_RESET;
    blink_period = BLINK_RESET;
    seen_level   = 1'b0;
    stable_age   = '0;
    pressed      = 1'b0;
    click_age    = CNT_MAX;
    clicks       = 2'd0;
    running      = 1'b0;
    backwards    = 1'b0;
    spot         = POS_RED;
    lamps        = 3'b000;
    blink_age    = '0;
    mismatches   = 0;
  endfunction

  function void set_register(cfg_idx_t idx, logic [CFG_W-1:0] val);
    case (idx)
      CFG_DEBOUNCE: debounce_lim = val[DEB_W-1:0];
      CFG_DCLICK:   dclick_win   = val[DCLK_W-1:0];
      CFG_BLINK:    blink_period = val[BLINK_W-1:0];
      default: ;
    endcase
  endfunction

  function logic [CNT_W-1:0] age_up(logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

  // Advance the model by one accepted tick and queue its result.
  function void note_tick(logic level, logic [1:0] cmd, logic hold);
    lamp_result_t r;
    r.stepped = 1'b0;

    if (level != seen_level) begin
      seen_level = level;
      stable_age = '0;
    end else begin
      stable_age = age_up(stable_age);
    end
    click_age = age_up(click_age);
    blink_age = age_up(blink_age);

    if (stable_age > {2'b00, debounce_lim}) begin
      if (level && !pressed) begin
        pressed = 1'b1;
        if (click_age < {2'b00, dclick_win})
          clicks = clicks + 2'd1;
        else
          clicks = 2'd1;
        click_age = '0;
      end else if (!level && pressed) begin
        pressed = 1'b0;
      end
    end

    if (clicks == 2'd2) begin
      running = ~running;
      if (running)
        backwards = ~backwards;
      clicks = 2'd0;
    end

    // remote command lands after the button on the same tick; code 3 is a no-op
    if (cmd == CMD_START) begin
      running   = 1'b1;
      backwards = ~backwards;
    end else if (cmd == CMD_STOP) begin
      running = 1'b0;
    end

    if (running || hold) begin
      if (blink_age >= blink_period) begin
        blink_age = '0;
        if (backwards)
          spot = (spot == POS_RED) ? POS_GREEN : spot - 2'd1;
        else
          spot = (spot == POS_GREEN) ? POS_RED : spot + 2'd1;
        lamps     = 3'b001 << spot;
        r.stepped = 1'b1;
      end
    end else begin
      lamps = 3'b000;
    end

    r.lamps = lamps;
    r.spot  = spot;
    r.run   = running;
    expected_results.push_back(r);
  endfunction

  function void check_result(logic [TDATA_W-1:0] data);
    lamp_result_t want;
    if (expected_results.size() == 0) begin
      $error("result with no tick outstanding: tdata %h", data);
      mismatches++;
      return;
    end
    want = expected_results.pop_front();
    if (data[2:0] !== want.lamps) begin
      $error("led_lamps: expected %0d, got %0d", want.lamps, data[2:0]);
      mismatches++;
    end
    if (data[3] !== want.stepped) begin
      $error("color_event: expected %0d, got %0d", want.stepped, data[3]);
      mismatches++;
    end
    if (data[5:4] !== want.spot) begin
      $error("color_now: expected %0d, got %0d", want.spot, data[5:4]);
      mismatches++;
    end
    if (data[6] !== want.run) begin
      $error("run_flag: expected %0d, got %0d", want.run, data[6]);
      mismatches++;
    end
  endfunction

  function int unsigned pending();
    return expected_results.size();
  endfunction
endclass

module tb_double_click_led_chaser;

  // Unused remote code, treated by the block as no command.
  localparam logic [1:0] CMD_SPARE = 2'd3;
  // Idle cycles with no transaction on either side before giving up.
  localparam int unsigned STALL_LIMIT = 20000;

  logic               clk;
  logic               rst;
  logic               s_tvalid;
  logic               s_tready;
  logic [TDATA_W-1:0] s_tdata;
  logic               m_tvalid;
  logic               m_tready;
  logic [TDATA_W-1:0] m_tdata;
  logic               cfg_we;
  logic [CFG_A_W-1:0] cfg_addr;
  logic [CFG_W-1:0]   cfg_data;

  chaser_scoreboard sb;
  int unsigned      ticks_sent;
  int unsigned      idle_cycles;
  bit               quiet_src;   // sender keeps tvalid up back to back
  bit               quiet_sink;  // receiver keeps tready up
  logic             hold_level;  // sticky remote hold, flips now and then

  double_click_led_chaser dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55)
      return 0;
    if (r < 90)
      return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  function automatic logic [1:0] pick_cmd();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 88)
      return CMD_NONE;
    if (r < 93)
      return CMD_START;
    if (r < 97)
      return CMD_STOP;
    return CMD_SPARE;
  endfunction

  function automatic logic next_hold();
    if ($urandom_range(29) == 0)
      hold_level = ~hold_level;
    return hold_level;
  endfunction

  // Length of one press or release: mostly long enough to get through the
  // debouncer, sometimes a short one that must be filtered out. A huge
  // debounce setting would cost thousands of ticks, so stay short there.
  function automatic int unsigned press_len(input logic [DEB_W-1:0] deb);
    if (deb > 20)
      return $urandom_range(10, 1);
    if ($urandom_range(6) == 0)
      return $urandom_range(deb + 1, 1);
    return deb + 1 + $urandom_range(3);
  endfunction

  // Drive one tick transaction. Entered and left at a falling edge.
  task automatic push_tick(input logic level, input logic [1:0] cmd, input logic hold);
    int unsigned gap;
    gap = quiet_src ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata  = {4'b0000, hold, cmd, level};
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    sb.note_tick(level, cmd, hold);
    ticks_sent++;
    @(negedge clk);
  endtask

  task automatic send_run(input logic level, input int unsigned len);
    repeat (len) push_tick(level, pick_cmd(), next_hold());
  endtask

  // Stop sending and let every outstanding result drain.
  task automatic wait_idle();
    s_tvalid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // Register write, only ever issued with the pipeline empty.
  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
    cfg_we   = 1'b1;
    cfg_addr = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we   = 1'b0;
    sb.set_register(idx, val);
  endtask

  task automatic set_periods(input logic [DEB_W-1:0] deb, input logic [DCLK_W-1:0] win,
                             input logic [BLINK_W-1:0] blink);
    wait_idle();
    write_reg(CFG_DEBOUNCE, {2'b00, deb});
    write_reg(CFG_DCLICK, {2'b00, win});
    write_reg(CFG_BLINK, blink);
  endtask

  // A stretch of random ticks under one register setting. Mostly single or
  // double clicks (with some contact bounce), the rest raw button noise.
  task automatic run_phase(input logic [DEB_W-1:0] deb, input logic [DCLK_W-1:0] win,
                           input logic [BLINK_W-1:0] blink, input int unsigned n,
                           input bit drain_midway);
    int unsigned first;
    int unsigned presses;
    bit          drained;
    set_periods(deb, win, blink);
    first   = ticks_sent;
    drained = 1'b0;
    while (ticks_sent - first < n) begin
      quiet_src  = ($urandom_range(3) == 0);
      quiet_sink = ($urandom_range(3) == 0);
      if (drain_midway && !drained && (ticks_sent - first >= n / 2)) begin
        wait_idle();
        drained = 1'b1;
      end
      if ($urandom_range(4) != 0) begin
        presses = ($urandom_range(3) == 0) ? 1 : 2;
        repeat (presses) begin
          if ($urandom_range(3) == 0)
            repeat ($urandom_range(4, 1)) send_run(1'($urandom_range(1)), 1);
          send_run(1'b1, press_len(deb));
          send_run(1'b0, press_len(deb));
        end
      end else begin
        repeat ($urandom_range(6, 1))
          send_run(1'($urandom_range(1)), $urandom_range(3, 1));
      end
    end
  endtask

  // Result side: random stalls on tready, checked at the rising edge.
  initial begin
    int unsigned stall;
    m_tready = 1'b0;
    stall    = 0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        m_tready = 1'b0;
        stall--;
      end else begin
        m_tready = 1'b1;
        if (!quiet_sink)
          stall = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_result(m_tdata);
  end

  // Watchdog: a hung handshake ends the run.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    sb          = new();
    ticks_sent  = 0;
    idle_cycles = 0;
    quiet_src   = 1'b0;
    quiet_sink  = 1'b0;
    hold_level  = 1'b0;
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    cfg_we      = 1'b0;
    cfg_addr    = '0;
    cfg_data    = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: reset periods, remote commands, the spare code and hold.
    push_tick(1'b0, CMD_NONE, 1'b0);
    push_tick(1'b1, CMD_START, 1'b0);
    push_tick(1'b0, CMD_SPARE, 1'b1);
    push_tick(1'b1, CMD_STOP, 1'b1);
    push_tick(1'b0, CMD_STOP, 1'b0);
    push_tick(1'b1, CMD_NONE, 1'b1);

    // Zero debounce, zero window, zero blink period.
    set_periods('0, '0, '0);
    push_tick(1'b1, CMD_NONE, 1'b0);   // same level as before: pressed at once
    push_tick(1'b1, CMD_NONE, 1'b0);   // still held: no second press
    push_tick(1'b0, CMD_NONE, 1'b0);
    push_tick(1'b0, CMD_NONE, 1'b0);
    push_tick(1'b1, CMD_NONE, 1'b0);
    push_tick(1'b1, CMD_NONE, 1'b0);   // zero window: never a second click
    push_tick(1'b0, CMD_START, 1'b0);  // steps every tick, direction flips
    push_tick(1'b0, CMD_NONE, 1'b0);
    push_tick(1'b0, CMD_STOP, 1'b0);   // lamps off
    push_tick(1'b0, CMD_NONE, 1'b1);   // held: stepping resumes
    push_tick(1'b0, CMD_SPARE, 1'b0);
    push_tick(1'b1, CMD_STOP, 1'b1);

    // Widest window: the first press pairs with the last; running toggles on.
    set_periods('0, 10'd1023, 12'd2);
    push_tick(1'b0, CMD_NONE, 1'b0);
    push_tick(1'b1, CMD_NONE, 1'b0);
    push_tick(1'b1, CMD_NONE, 1'b0);
    push_tick(1'b0, CMD_NONE, 1'b0);
    push_tick(1'b0, CMD_NONE, 1'b0);
    push_tick(1'b1, CMD_NONE, 1'b0);
    push_tick(1'b1, CMD_NONE, 1'b0);

    // Random part under a spread of settings, the extremes among them.
    run_phase(10'd2, 10'd15, 12'd3, 200, 1'b0);
    run_phase(10'd0, 10'd1023, 12'd1, 150, 1'b0);
    run_phase(10'd1023, 10'd1, 12'd4095, 60, 1'b0);
    run_phase(10'd5, 10'd40, 12'd0, 200, 1'b1);
    run_phase(10'd1, 10'd6, 12'd7, 200, 1'b0);

    wait_idle();
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

>>> files.f
+incdir+sv
sv/dclc_pkg.sv
sv/dclc_click.sv
sv/dclc_chaser.sv
sv/double_click_led_chaser.sv
sv/dclc_checker.sv
test/tb_double_click_led_chaser.sv
